// File: src/cpfa_pkg.sv
package cpfa_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 1'd1;

  localparam logic [DATA_W-1:0]  BASE_ADDRESS_RST = 32'h0000_0000;
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST  = 11'd1024;
  localparam logic [DATA_W-1:0]  KSEG0_OFFSET     = 32'h8000_0000;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   addr_t;
  typedef logic [COUNT_W-1:0]  count_t;

endpackage

// File: src/cpfa_req_if.sv
interface cpfa_req_if
  import cpfa_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   func;
  count_t page_count;
  addr_t  free_address;

  modport source (output valid, output func, output page_count, output free_address,
                  input ready);
  modport sink (input valid, input func, input page_count, input free_address,
                output ready);
endinterface

// File: src/cpfa_rsp_if.sv
interface cpfa_rsp_if
  import cpfa_pkg::*;
  ();
  logic    valid;
  logic    ready;
  status_t status;
  addr_t   phys_address;

  modport source (output valid, output status, output phys_address, input ready);
  modport sink (input valid, input status, input phys_address, output ready);
endinterface

// File: src/contiguous_page_frame_allocator.sv
// Channel  Direction  Contents
// req      in         func, page_count, free_address
// rsp      out        status, phys_address
// cfg      in         cfg_write, cfg_index, cfg_data (base_address, frame_count)
//
// After reset the frame map is cleared one entry a cycle, all MAX_FRAMES entries, with req held off.
// An allocate scans the map: it reads one map entry a cycle from the single map read port,
// then the run is marked one frame a cycle.
// A free walks the chain, reading each frame's entry and then clearing it.
// One request is handled at a time; a stalled rsp holds the finished result in a register
// while the next request is accepted, and a later result waits until the slot is free.
module contiguous_page_frame_allocator
  import cpfa_pkg::*;
  #(
    parameter int MAX_FRAMES = 1024,
    parameter int PAGE_SHIFT = 12
  ) (
    input  logic                 clk,
    input  logic                 rst,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    cpfa_req_if.sink             req,
    cpfa_rsp_if.source           rsp
  );

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = ($clog2(MAX_FRAMES + 1) > COUNT_W) ? $clog2(MAX_FRAMES + 1) : COUNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_WRD   = 3'd5;
  localparam logic [2:0] S_WEV   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state, state_next;

  addr_t  base_address;
  count_t frame_count;

  logic   req_func;
  count_t req_count;
  addr_t  req_addr;

  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [CNT_W-1:0] issue_idx, issue_idx_next;
  logic             pend, pend_next;
  logic [CNT_W-1:0] pend_idx, pend_idx_next;
  logic [CNT_W-1:0] run, run_next;
  logic [CNT_W-1:0] start, start_next;
  logic [CNT_W-1:0] mark_idx, mark_idx_next;
  logic [CNT_W-1:0] remain, remain_next;
  logic [CNT_W-1:0] walk_idx, walk_idx_next;
  status_t          res_status, res_status_next;
  addr_t            res_addr, res_addr_next;

  logic    out_valid, out_valid_next;
  status_t out_status;
  addr_t   out_addr;
  logic    out_load;

  // Each entry holds {used, continues}.
  logic [1:0]       map_mem [MAX_FRAMES];
  logic [1:0]       rdata;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [1:0]       mem_wdata;

  logic [CNT_W-1:0] n_frames;
  logic [CNT_W-1:0] want;
  addr_t            free_off;
  addr_t            free_idx;
  logic             req_xfer;

  assign n_frames = (CNT_W'(frame_count) < CNT_W'(MAX_FRAMES)) ? CNT_W'(frame_count)
                                                               : CNT_W'(MAX_FRAMES);
  assign want     = CNT_W'(req_count);
  assign free_off = (req_addr - base_address) ^ KSEG0_OFFSET;
  assign free_idx = free_off >> PAGE_SHIFT;

  assign req.ready        = (state == S_IDLE);
  assign req_xfer         = req.valid && req.ready;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.phys_address = out_addr;

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    issue_idx_next  = issue_idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    run_next        = run;
    start_next      = start;
    mark_idx_next   = mark_idx;
    remain_next     = remain;
    walk_idx_next   = walk_idx;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    out_valid_next  = out_valid && !rsp.ready;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = 2'b00;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == IDX_W'(MAX_FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          state_next = S_START;
        end
      end
      S_START: begin
        res_addr_next = '0;
        if (req_func == FN_ALLOC) begin
          if (req_count == '0) begin
            res_status_next = ST_BAD;
            state_next      = S_RESP;
          end else begin
            issue_idx_next = '0;
            pend_next      = 1'b0;
            run_next       = '0;
            start_next     = '0;
            state_next     = S_SCAN;
          end
        end else begin
          if (free_idx >= DATA_W'(n_frames)) begin
            res_status_next = ST_BAD;
            state_next      = S_RESP;
          end else begin
            walk_idx_next = free_idx[CNT_W-1:0];
            state_next    = S_WRD;
          end
        end
      end
      S_SCAN: begin
        if (pend && !rdata[1] && (run + 1'b1 == want)) begin
          res_status_next = ST_DONE;
          res_addr_next   = (DATA_W'(start) << PAGE_SHIFT) + base_address;
          mark_idx_next   = start;
          remain_next     = want;
          pend_next       = 1'b0;
          state_next      = S_MARK;
        end else begin
          if (pend) begin
            if (rdata[1]) begin
              run_next   = '0;
              start_next = pend_idx + 1'b1;
            end else begin
              run_next = run + 1'b1;
            end
          end
          if (issue_idx < n_frames) begin
            mem_re         = 1'b1;
            mem_raddr      = issue_idx[IDX_W-1:0];
            pend_next      = 1'b1;
            pend_idx_next  = issue_idx;
            issue_idx_next = issue_idx + 1'b1;
          end else begin
            pend_next = 1'b0;
            if (!pend) begin
              res_status_next = ST_NO_FIT;
              res_addr_next   = '0;
              state_next      = S_RESP;
            end
          end
        end
      end
      S_MARK: begin
        mem_we        = 1'b1;
        mem_waddr     = mark_idx[IDX_W-1:0];
        mem_wdata     = {1'b1, remain != CNT_W'(1)};
        mark_idx_next = mark_idx + 1'b1;
        remain_next   = remain - 1'b1;
        if (remain == CNT_W'(1)) begin
          state_next = S_RESP;
        end
      end
      S_WRD: begin
        mem_re     = 1'b1;
        mem_raddr  = walk_idx[IDX_W-1:0];
        state_next = S_WEV;
      end
      S_WEV: begin
        mem_we    = 1'b1;
        mem_waddr = walk_idx[IDX_W-1:0];
        if (rdata[0] && (walk_idx + 1'b1 < n_frames)) begin
          walk_idx_next = walk_idx + 1'b1;
          state_next    = S_WRD;
        end else begin
          res_status_next = ST_DONE;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= map_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
      base_address <= BASE_ADDRESS_RST;
      frame_count  <= FRAME_COUNT_RST;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        if (cfg_index == REG_BASE_ADDRESS) begin
          base_address <= cfg_data;
        end
        if (cfg_index == REG_FRAME_COUNT) begin
          frame_count <= cfg_data[COUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_idx  <= issue_idx_next;
    pend_idx   <= pend_idx_next;
    run        <= run_next;
    start      <= start_next;
    mark_idx   <= mark_idx_next;
    remain     <= remain_next;
    walk_idx   <= walk_idx_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    if (req_xfer) begin
      req_func  <= req.func;
      req_count <= req.page_count;
      req_addr  <= req.free_address;
    end
    if (out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

endmodule

// File: src/cpfa_checker.sv
module cpfa_checker
  import cpfa_pkg::*;
  (
    input logic    clk,
    input logic    rst,
    input logic    req_valid,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input status_t rsp_status,
    input addr_t   rsp_phys_address
  );

  // A stalled result keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_phys_address))
    else $error("result changed while stalled");

  // Only a completed allocate carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_DONE) |-> rsp_phys_address == '0)
    else $error("failed request returned an address");

  // One request at a time: a transfer closes the request channel.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // Reset starts the map clearing, so neither channel is open afterwards.
  a_reset: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("channel open straight after reset");

endmodule

bind contiguous_page_frame_allocator cpfa_checker u_cpfa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_phys_address (rsp.phys_address)
);
